### hw/rtl/grr_pkg.sv
// Shared types, constants and the 5x8 font table for the glyph row rasterizer.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package grr_pkg;

   localparam int unsigned ROWS        = 10;
   localparam int unsigned GLYPH_H     = 8;
   localparam int unsigned GLYPH_W     = 5;
   localparam int unsigned ADVANCE     = 6;
   localparam int unsigned FIRST_CODE  = 31;
   localparam int unsigned LAST_CODE   = 126;
   localparam int unsigned QMARK_INDEX = 32;   // '?' minus the first code
   localparam int unsigned ROW_W       = 4;
   localparam int unsigned QUEUE_DEPTH = 2;    // power of two: pointers wrap freely
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_STOP,        // one clipped beat, masks zero
      KIND_EDGE_LEAD,   // ten clipped beats carrying the leading spacing column
      KIND_DRAW_LEAD,   // ten beats, 7-pixel segment with leading spacing
      KIND_DRAW_NEXT    // ten beats, 6-pixel segment
   } kind_type;

   typedef struct packed {
      logic        mode;
      logic [7:0]  char_code;
      logic [8:0]  start_x;
      logic [7:0]  start_y;
      logic [15:0] fore_color;
      logic [15:0] back_color;
      logic        fore_clear;
      logic        back_clear;
      logic        swap_colors;
   } req_type;

   typedef struct packed {
      logic [8:0]  seg_x;
      logic [7:0]  seg_y;
      logic [6:0]  write_mask;
      logic [6:0]  fore_mask;
      logic [15:0] out_fore;
      logic [15:0] out_back;
      logic        clipped;
      logic        last;
   } rsp_type;

   // Column 0 of the glyph sits in the top byte.
   typedef struct packed {
      kind_type    kind;
      logic [8:0]  seg_x;
      logic [7:0]  seg_y;
      logic [39:0] glyph;
      logic [15:0] fore;
      logic [15:0] back;
      logic        fore_clear;
      logic        back_clear;
   } cmd_type;

   function automatic logic [39:0] glyph_cols(input logic [6:0] idx);
      logic [39:0] g;
      case (idx)
         7'd0:  g = 40'hFF_FF_FF_FF_FF;
         7'd1:  g = 40'h00_00_00_00_00;
         7'd2:  g = 40'h00_6F_6F_00_00;
         7'd3:  g = 40'h05_03_00_05_03;
         7'd4:  g = 40'h14_3E_14_3E_14;
         7'd5:  g = 40'h2E_2A_7F_2A_3A;
         7'd6:  g = 40'h43_33_08_66_61;
         7'd7:  g = 40'h36_49_55_22_58;
         7'd8:  g = 40'h00_05_03_00_00;
         7'd9:  g = 40'h00_3C_42_81_00;
         7'd10: g = 40'h00_81_42_3C_00;
         7'd11: g = 40'h28_10_7C_10_28;
         7'd12: g = 40'h08_08_3E_08_08;
         7'd13: g = 40'h00_A0_60_00_00;
         7'd14: g = 40'h08_08_08_08_08;
         7'd15: g = 40'h00_60_60_00_00;
         7'd16: g = 40'hC0_30_0C_03_00;
         7'd17: g = 40'h3E_51_49_45_3E;
         7'd18: g = 40'h44_42_7F_40_40;
         7'd19: g = 40'h42_61_51_49_46;
         7'd20: g = 40'h22_41_49_49_36;
         7'd21: g = 40'h0F_08_08_08_7F;
         7'd22: g = 40'h27_45_45_45_39;
         7'd23: g = 40'h3E_49_49_49_32;
         7'd24: g = 40'h01_01_61_19_07;
         7'd25: g = 40'h36_49_49_49_36;
         7'd26: g = 40'h26_49_49_49_3E;
         7'd27: g = 40'h00_36_36_00_00;
         7'd28: g = 40'h00_56_36_00_00;
         7'd29: g = 40'h08_14_22_41_00;
         7'd30: g = 40'h14_14_14_14_14;
         7'd31: g = 40'h41_22_14_08_00;
         7'd32: g = 40'h02_01_51_09_06;
         7'd33: g = 40'h3C_42_5A_52_4C;
         7'd34: g = 40'h7E_09_09_09_7E;
         7'd35: g = 40'h7F_49_49_49_36;
         7'd36: g = 40'h3E_41_41_41_22;
         7'd37: g = 40'h7F_41_41_22_1C;
         7'd38: g = 40'h7F_49_49_49_49;
         7'd39: g = 40'h7F_09_09_09_09;
         7'd40: g = 40'h3E_41_49_49_3A;
         7'd41: g = 40'h7F_08_08_08_7F;
         7'd42: g = 40'h41_41_7F_41_41;
         7'd43: g = 40'h31_41_41_3F_01;
         7'd44: g = 40'h7F_08_14_22_41;
         7'd45: g = 40'h7F_40_40_40_40;
         7'd46: g = 40'h7F_02_04_02_7F;
         7'd47: g = 40'h7F_02_04_08_7F;
         7'd48: g = 40'h3E_41_41_41_3E;
         7'd49: g = 40'h7F_09_09_09_06;
         7'd50: g = 40'h3E_41_51_21_5E;
         7'd51: g = 40'h7F_09_19_29_46;
         7'd52: g = 40'h26_49_49_49_32;
         7'd53: g = 40'h01_01_7F_01_01;
         7'd54: g = 40'h3F_40_40_40_3F;
         7'd55: g = 40'h0F_30_40_30_0F;
         7'd56: g = 40'h1F_60_1C_60_1F;
         7'd57: g = 40'h63_14_08_14_63;
         7'd58: g = 40'h03_04_78_04_03;
         7'd59: g = 40'h61_51_49_45_43;
         7'd60: g = 40'h00_FF_81_81_00;
         7'd61: g = 40'h03_0C_30_C0_00;
         7'd62: g = 40'h00_81_81_FF_00;
         7'd63: g = 40'h04_02_01_02_04;
         7'd64: g = 40'h40_40_40_40_40;
         7'd65: g = 40'h00_01_02_04_00;
         7'd66: g = 40'h38_44_44_24_78;
         7'd67: g = 40'h7F_48_44_44_38;
         7'd68: g = 40'h38_44_44_44_44;
         7'd69: g = 40'h38_44_44_48_7F;
         7'd70: g = 40'h38_54_54_54_18;
         7'd71: g = 40'h08_08_7E_09_09;
         7'd72: g = 40'h18_A4_A4_A4_78;
         7'd73: g = 40'h7F_08_04_04_78;
         7'd74: g = 40'h00_44_7D_40_00;
         7'd75: g = 40'h40_80_80_7D_00;
         7'd76: g = 40'h7F_10_28_44_00;
         7'd77: g = 40'h00_41_7F_40_00;
         7'd78: g = 40'h7C_04_78_04_78;
         7'd79: g = 40'h7C_08_04_04_78;
         7'd80: g = 40'h38_44_44_44_38;
         7'd81: g = 40'hFC_24_24_24_18;
         7'd82: g = 40'h18_24_24_24_F8;
         7'd83: g = 40'h7C_08_04_04_08;
         7'd84: g = 40'h48_54_54_54_24;
         7'd85: g = 40'h04_04_3E_44_44;
         7'd86: g = 40'h3C_40_40_20_7C;
         7'd87: g = 40'h1C_20_40_20_1C;
         7'd88: g = 40'h1C_60_1C_60_1C;
         7'd89: g = 40'h44_28_10_28_44;
         7'd90: g = 40'h1C_A0_A0_A0_7C;
         7'd91: g = 40'h44_64_54_4C_44;
         7'd92: g = 40'h00_08_76_81_00;
         7'd93: g = 40'h00_00_FF_00_00;
         7'd94: g = 40'h00_81_76_08_00;
         7'd95: g = 40'h08_04_08_10_08;
         default: g = 40'h00_00_00_00_00;
      endcase
      return g;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/grr_front.sv
// Front end: accepts characters, tracks the string cursor and halt flag, classifies
// each character and fetches its glyph columns. Depends on grr_pkg.
`default_nettype none

module grr_front #(
   parameter int unsigned SCREEN_WIDTH  = 396,
   parameter int unsigned SCREEN_HEIGHT = 224
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   input  grr_pkg::req_type    req_data,
   input  wire                 queue_full,
   output logic                cmd_write,
   output grr_pkg::cmd_type    cmd_data
);

   logic [8:0] cursor_x_ff, cursor_x_in;
   logic [7:0] cursor_y_ff, cursor_y_in;
   logic       halted_ff, halted_in;

   logic       accept;
   logic [8:0] cx;
   logic [7:0] cy;
   logic       start_oob;
   logic       edge_hit;
   logic       code_ok;
   logic [6:0] glyph_idx;
   grr_pkg::kind_type kind;

   always_comb begin
      accept    = push & ~queue_full;
      cx        = req_data.mode ? req_data.start_x : cursor_x_ff;
      cy        = req_data.mode ? req_data.start_y : cursor_y_ff;
      start_oob = (req_data.start_x >= 9'(SCREEN_WIDTH)) |
                  (({1'b0, req_data.start_y} + 9'(grr_pkg::ROWS)) > 9'(SCREEN_HEIGHT));
      edge_hit  = ({1'b0, cx} + 10'(grr_pkg::ADVANCE)) >= 10'(SCREEN_WIDTH);

      if (req_data.mode && start_oob) begin
         kind = grr_pkg::KIND_STOP;
      end else if (!req_data.mode && halted_ff) begin
         kind = grr_pkg::KIND_STOP;
      end else if (edge_hit) begin
         kind = req_data.mode ? grr_pkg::KIND_EDGE_LEAD : grr_pkg::KIND_STOP;
      end else begin
         kind = req_data.mode ? grr_pkg::KIND_DRAW_LEAD : grr_pkg::KIND_DRAW_NEXT;
      end

      // Map codes outside the font to '?'
      code_ok   = (req_data.char_code >= 8'(grr_pkg::FIRST_CODE)) &
                  (req_data.char_code <= 8'(grr_pkg::LAST_CODE));
      glyph_idx = code_ok ? 7'(req_data.char_code - 8'(grr_pkg::FIRST_CODE))
                          : 7'(grr_pkg::QMARK_INDEX);

      cmd_write           = accept;
      cmd_data.kind       = kind;
      cmd_data.seg_x      = (kind == grr_pkg::KIND_DRAW_NEXT) ? 9'(cx + 9'd1) : cx;
      cmd_data.seg_y      = cy;
      cmd_data.glyph      = grr_pkg::glyph_cols(glyph_idx);
      cmd_data.fore       = req_data.swap_colors ? req_data.back_color : req_data.fore_color;
      cmd_data.back       = req_data.swap_colors ? req_data.fore_color : req_data.back_color;
      cmd_data.fore_clear = req_data.swap_colors ? req_data.back_clear : req_data.fore_clear;
      cmd_data.back_clear = req_data.swap_colors ? req_data.fore_clear : req_data.back_clear;

      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      halted_in   = halted_ff;
      if (accept) begin
         cursor_x_in = cx;
         cursor_y_in = cy;
         if (req_data.mode && start_oob) begin
            halted_in = 1'b1;
         end else if (req_data.mode || !halted_ff) begin
            halted_in = edge_hit;
            if (!edge_hit) begin
               cursor_x_in = 9'(cx + 9'(grr_pkg::ADVANCE));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         halted_ff   <= 1'b1;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         halted_ff   <= halted_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/grr_queue.sv
// Short command queue between front and back end.
// Depends on grr_pkg for the command type and depth.
`default_nettype none

module grr_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 wr_en,
   input  grr_pkg::cmd_type    wr_data,
   output logic                full,
   input  wire                 rd_en,
   output logic                rd_valid,
   output grr_pkg::cmd_type    rd_data
);

   grr_pkg::cmd_type                    mem_ff [grr_pkg::QUEUE_DEPTH];
   logic [grr_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [grr_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [grr_pkg::QCNT_W-1:0]          count_ff, count_in;

   always_comb begin
      full      = (count_ff == grr_pkg::QCNT_W'(grr_pkg::QUEUE_DEPTH));
      rd_valid  = (count_ff != '0);
      rd_data   = mem_ff[rd_ptr_ff];
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = rd_en ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + grr_pkg::QCNT_W'(wr_en) - grr_pkg::QCNT_W'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/grr_back.sv
// Back end: steps the head command's ten rows (one for a stop) into the output
// register, one beat a cycle unless pop stalls it. Depends on grr_pkg.
`default_nettype none

module grr_back (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 cmd_valid,
   input  grr_pkg::cmd_type    cmd_data,
   output logic                cmd_done,
   output logic                empty,
   input  wire                 pop,
   output grr_pkg::rsp_type    rsp_data
);

   logic [grr_pkg::ROW_W-1:0] row_ff, row_in;
   logic                      valid_ff, valid_in;
   grr_pkg::rsp_type          rsp_ff, rsp_in;

   logic                      advance;
   logic                      final_row;
   logic [grr_pkg::ROW_W-1:0] row_m1;
   logic                      glyph_row;
   logic [4:0]                col_bits;
   logic [6:0]                fm;
   logic [6:0]                span;
   logic [6:0]                wm;
   logic                      lead;

   always_comb begin
      advance   = cmd_valid & (~valid_ff | pop);
      row_m1    = row_ff - 1'b1;
      glyph_row = (row_ff >= grr_pkg::ROW_W'(1)) &
                  (row_ff <= grr_pkg::ROW_W'(grr_pkg::GLYPH_H));
      for (int i = 0; i < 5; i++) begin
         col_bits[i] = glyph_row & cmd_data.glyph[39 - 8*i - 7 + int'(row_m1[2:0])];
      end

      lead = (cmd_data.kind == grr_pkg::KIND_DRAW_LEAD);
      fm   = lead ? {1'b0, col_bits, 1'b0} : {2'b00, col_bits};
      span = lead ? 7'h7F : 7'h3F;
      wm   = (cmd_data.fore_clear ? 7'h00 : fm) | (cmd_data.back_clear ? 7'h00 : (span & ~fm));

      final_row = (row_ff == grr_pkg::ROW_W'(grr_pkg::ROWS - 1));

      rsp_in.seg_x    = cmd_data.seg_x;
      rsp_in.seg_y    = cmd_data.seg_y + 8'(row_ff);
      rsp_in.out_fore = cmd_data.fore;
      rsp_in.out_back = cmd_data.back;
      case (cmd_data.kind)
         grr_pkg::KIND_STOP: begin
            rsp_in.write_mask = 7'h00;
            rsp_in.fore_mask  = 7'h00;
            rsp_in.clipped    = 1'b1;
            final_row         = 1'b1;
         end
         grr_pkg::KIND_EDGE_LEAD: begin
            rsp_in.write_mask = {6'h00, ~cmd_data.back_clear};
            rsp_in.fore_mask  = 7'h00;
            rsp_in.clipped    = 1'b1;
         end
         default: begin
            rsp_in.write_mask = wm;
            rsp_in.fore_mask  = fm;
            rsp_in.clipped    = 1'b0;
         end
      endcase
      rsp_in.last = final_row;

      cmd_done = advance & final_row;

      row_in   = row_ff;
      valid_in = valid_ff;
      if (advance) begin
         valid_in = 1'b1;
         row_in   = final_row ? '0 : row_ff + 1'b1;
      end else if (pop) begin
         valid_in = 1'b0;
      end

      empty    = ~valid_ff;
      rsp_data = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/glyph_row_rasterizer.sv
// Top level of the glyph row rasterizer: front end, command queue, row back end.
// Depends on grr_pkg, grr_front, grr_queue and grr_back.
//
//   channel   ports                    direction   beat
//   request   push, full, req_data     in          one character
//   response  empty, pop, rsp_data     out         one pixel-row segment
//
// A drawn character, and a first character clipped at the right edge, gives ten
// beats at one per cycle while pop keeps up; other clipped characters give one beat.
// The row sequencer in the back end sets the rate.
// A two-entry queue lets the front take new characters while rows are still going out.
// Reset clears the cursor to the origin and halts the string until a first character.
// A stalled pop holds the output register and, once the queue fills, raises full.
`default_nettype none

module glyph_row_rasterizer #(
   parameter int unsigned SCREEN_WIDTH  = 396,
   parameter int unsigned SCREEN_HEIGHT = 224
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push,
   output logic                full,
   input  grr_pkg::req_type    req_data,
   output logic                empty,
   input  wire                 pop,
   output grr_pkg::rsp_type    rsp_data
);

   logic             cmd_write;
   grr_pkg::cmd_type cmd_wdata;
   logic             queue_full;
   logic             cmd_valid;
   grr_pkg::cmd_type cmd_rdata;
   logic             cmd_done;

   assign full = queue_full;

   grr_front #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_data   (req_data),
      .queue_full (queue_full),
      .cmd_write  (cmd_write),
      .cmd_data   (cmd_wdata)
   );

   grr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_write),
      .wr_data  (cmd_wdata),
      .full     (queue_full),
      .rd_en    (cmd_done),
      .rd_valid (cmd_valid),
      .rd_data  (cmd_rdata)
   );

   grr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_rdata),
      .cmd_done  (cmd_done),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire
